@@ sv/btmx_pkg.sv @@
// Package for the binary trie maximum XOR block.
// Holds the sizing constants and the saturating count update.
// Depends on nothing; binary_trie_max_xor and btmx_checker import it.
package btmx_pkg;

    // Trie depth, node pool size and width of the per-node counts.
    localparam int KEY_BITS   = 31;
    localparam int MAX_NODES  = 65536;
    localparam int COUNT_BITS = 20;

    // Fixed widths of the item fields.
    localparam int KEY_W   = 31;
    localparam int DELTA_W = 8;

    // Derived widths.
    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int LINK_W = 2 * NODE_W;
    localparam int DEP_W  = $clog2(KEY_BITS + 1);
    localparam int IDX_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
    localparam int CMP_W  = NODE_W + DEP_W;
    localparam int SUM_W  = ((COUNT_BITS > DELTA_W) ? COUNT_BITS : DELTA_W) + 2;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic signed [SUM_W-1:0] SUM_MAX =
        SUM_W'((64'd1 << COUNT_BITS) - 64'd1);

    // Adds a signed delta to a count and clamps the sum to the count range.
    function automatic logic [COUNT_BITS-1:0] sat_add(
        input logic [COUNT_BITS-1:0]     cnt,
        input logic signed [DELTA_W-1:0] delta
    );
        logic signed [SUM_W-1:0] sum;
        sum = $signed({{(SUM_W - COUNT_BITS){1'b0}}, cnt}) + SUM_W'(delta);
        if (sum < 0) begin
            return '0;
        end else if (sum > SUM_MAX) begin
            return CNT_MAX;
        end else begin
            return sum[COUNT_BITS-1:0];
        end
    endfunction

endpackage

@@ sv/btmx_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the trie link store and the node count store; no dependencies.
module btmx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port, and a read port whose data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/binary_trie_max_xor.sv @@
// Binary trie holding a multiset of keys, with updates and maximum XOR queries.
// Depends on btmx_pkg and two btmx_ram instances.
//
// Usage:
//   Input channel i_valid / o_stall carries one item: i_mode, i_key, i_delta.
//   Mode 0 adds the signed delta to the key's multiplicity; mode 1 asks for the
//   largest XOR of the key with any stored key. Every item gives one result
//   item on o_valid / i_stall: o_max_xor, o_set_empty, o_pool_full.
//   One item is worked on at a time; o_stall is high from the cycle after an
//   item is taken until its result moves into the output register.
//   A query walks one trie level at a time and ends early for an empty set or a
//   dead end: each trie level needs a link read and then a dependent count read
//   on the shared count RAM port. An update runs a link walk, a pipelined count
//   pass over the existing path nodes, then allocates one new node per cycle.
//   The next item can be taken as soon as the result is registered.
//   Reset clears the root links and the pool pointer; nodes are zeroed as they
//   are allocated, so no clearing pass over the RAMs is run.
//   While the receiver stalls, the result holds in the output register and the
//   next item may still be taken and worked on; it then waits for the slot.
module binary_trie_max_xor
    import btmx_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_mode,
    input  logic [KEY_W-1:0]          i_key,
    input  logic signed [DELTA_W-1:0] i_delta,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [KEY_W-1:0]          o_max_xor,
    output logic                      o_set_empty,
    output logic                      o_pool_full
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK   = 4'd1;
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] S_UPD   = 4'd3;
    localparam logic [3:0] S_ALLOC = 4'd4;
    localparam logic [3:0] S_QE0   = 4'd5;
    localparam logic [3:0] S_QE1   = 4'd6;
    localparam logic [3:0] S_QE2   = 4'd7;
    localparam logic [3:0] S_QA    = 4'd8;
    localparam logic [3:0] S_QB    = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    // Control registers.
    logic [3:0]        r_state, n_state;
    logic              r_out_valid, n_out_valid;
    logic [NODE_W-1:0] r_free, n_free;
    logic [NODE_W-1:0] r_root0, n_root0;
    logic [NODE_W-1:0] r_root1, n_root1;
    logic              r_pend, n_pend;

    // Working and payload registers.
    logic [KEY_BITS-1:0]       r_key, n_key;
    logic signed [DELTA_W-1:0] r_delta, n_delta;
    logic [KEY_BITS-1:0]       r_res, n_res;
    logic                      r_empty, n_empty;
    logic                      r_full, n_full;
    logic [DEP_W-1:0]          r_depth, n_depth;
    logic [DEP_W-1:0]          r_upd_k, n_upd_k;
    logic [NODE_W-1:0]         r_node, n_node;
    logic                      r_at_root, n_at_root;
    logic [LINK_W-1:0]         r_par_links, n_par_links;
    logic                      r_par_root, n_par_root;
    logic [NODE_W-1:0]         r_par_node, n_par_node;
    logic [NODE_W-1:0]         r_path [KEY_BITS];
    logic [NODE_W-1:0]         n_path [KEY_BITS];
    logic [NODE_W-1:0]         r_pend_addr, n_pend_addr;
    logic [NODE_W-1:0]         r_opp, n_opp;
    logic [NODE_W-1:0]         r_same, n_same;
    logic                      r_nz0, n_nz0;
    logic [KEY_W-1:0]          r_out_max_xor, n_out_max_xor;
    logic                      r_out_empty, n_out_empty;
    logic                      r_out_full, n_out_full;

    // RAM ports.
    logic                  lk_we, lk_re;
    logic [NODE_W-1:0]     lk_waddr, lk_raddr;
    logic [LINK_W-1:0]     lk_wdata, lk_rdata;
    logic                  cnt_we, cnt_re;
    logic [NODE_W-1:0]     cnt_waddr, cnt_raddr;
    logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;

    // Helper values.
    logic [63:0]       w_key64, w_res64;
    logic [IDX_W-1:0]  w_bidx, w_nbidx;
    logic              w_kbit, w_nkbit, w_last;
    logic [LINK_W-1:0] w_cur, w_plink, w_alink;
    logic [NODE_W-1:0] w_nxt, w_oppv, w_newn, w_newn1;
    logic [CMP_W-1:0]  w_missing, w_avail;
    logic              w_in_acc, w_out_free, w_qtake;
    logic [NODE_W-1:0] w_qtarget;

    btmx_ram #(.WIDTH(LINK_W), .DEPTH(MAX_NODES)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (lk_we),
        .i_waddr (lk_waddr),
        .i_wdata (lk_wdata),
        .i_re    (lk_re),
        .i_raddr (lk_raddr),
        .o_rdata (lk_rdata)
    );

    btmx_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_NODES)) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (cnt_re),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    // Handshake.
    assign o_stall    = (r_state != S_IDLE) || !i_rst_n;
    assign w_in_acc   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;

    // Key bit of the current level and of the level below it.
    assign w_key64 = 64'(i_key);
    assign w_res64 = 64'(r_res);
    assign w_bidx  = IDX_W'(DEP_W'(KEY_BITS - 1) - r_depth);
    assign w_nbidx = IDX_W'(DEP_W'(KEY_BITS - 2) - r_depth);
    assign w_kbit  = r_key[w_bidx];
    assign w_nkbit = r_key[w_nbidx];
    assign w_last  = (r_depth == DEP_W'(KEY_BITS - 1));

    // Links of the current node: the root lives in flip-flops.
    assign w_cur  = r_at_root ? {r_root1, r_root0} : lk_rdata;
    assign w_nxt  = w_kbit ? w_cur[LINK_W-1:NODE_W] : w_cur[NODE_W-1:0];
    assign w_oppv = w_kbit ? w_cur[NODE_W-1:0] : w_cur[LINK_W-1:NODE_W];

    // Allocation: the next free node and the link words written for it.
    assign w_newn  = r_free + NODE_W'(1);
    assign w_newn1 = w_newn + NODE_W'(1);
    assign w_plink = w_kbit ? {w_newn, r_par_links[NODE_W-1:0]}
                            : {r_par_links[LINK_W-1:NODE_W], w_newn};
    assign w_alink = w_last  ? '0 :
                     w_nkbit ? {w_newn1, {NODE_W{1'b0}}} : {{NODE_W{1'b0}}, w_newn1};

    // Pool space check.
    assign w_missing = CMP_W'(KEY_BITS) - CMP_W'(r_depth);
    assign w_avail   = CMP_W'(MAX_NODES - 1) - CMP_W'(r_free);

    // Query step: take the opposite branch when it holds keys.
    assign w_qtake   = (r_opp != '0) && (cnt_rdata != '0);
    assign w_qtarget = w_qtake ? r_opp : r_same;

    // Sequencer.
    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid && i_stall;
        n_free        = r_free;
        n_root0       = r_root0;
        n_root1       = r_root1;
        n_pend        = r_pend;
        n_key         = r_key;
        n_delta       = r_delta;
        n_res         = r_res;
        n_empty       = r_empty;
        n_full        = r_full;
        n_depth       = r_depth;
        n_upd_k       = r_upd_k;
        n_node        = r_node;
        n_at_root     = r_at_root;
        n_par_links   = r_par_links;
        n_par_root    = r_par_root;
        n_par_node    = r_par_node;
        n_path        = r_path;
        n_pend_addr   = r_pend_addr;
        n_opp         = r_opp;
        n_same        = r_same;
        n_nz0         = r_nz0;
        n_out_max_xor = r_out_max_xor;
        n_out_empty   = r_out_empty;
        n_out_full    = r_out_full;
        lk_we         = 1'b0;
        lk_waddr      = '0;
        lk_wdata      = '0;
        lk_re         = 1'b0;
        lk_raddr      = '0;
        cnt_we        = 1'b0;
        cnt_waddr     = '0;
        cnt_wdata     = '0;
        cnt_re        = 1'b0;
        cnt_raddr     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_key     = w_key64[KEY_BITS-1:0];
                    n_delta   = i_delta;
                    n_res     = '0;
                    n_empty   = 1'b0;
                    n_full    = 1'b0;
                    n_depth   = '0;
                    n_upd_k   = '0;
                    n_node    = '0;
                    n_at_root = 1'b1;
                    n_pend    = 1'b0;
                    n_state   = i_mode ? S_QE0 : S_CHK;
                end
            end

            // Walk the existing part of the key's path, one level a cycle.
            S_CHK: begin
                if (w_nxt == '0) begin
                    n_par_links = w_cur;
                    n_par_root  = r_at_root;
                    n_par_node  = r_node;
                    n_state     = S_DEC;
                end else begin
                    n_path[r_depth[IDX_W-1:0]] = w_nxt;
                    lk_re     = 1'b1;
                    lk_raddr  = w_nxt;
                    n_node    = w_nxt;
                    n_at_root = 1'b0;
                    n_depth   = r_depth + DEP_W'(1);
                    if (w_last) begin
                        n_state = S_DEC;
                    end
                end
            end

            // Drop the update if the new nodes do not fit, else hook the
            // first new node under the last existing one.
            S_DEC: begin
                if (w_missing > w_avail) begin
                    n_full  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    if (r_depth != DEP_W'(KEY_BITS)) begin
                        if (r_par_root) begin
                            n_root0 = w_plink[NODE_W-1:0];
                            n_root1 = w_plink[LINK_W-1:NODE_W];
                        end else begin
                            lk_we    = 1'b1;
                            lk_waddr = r_par_node;
                            lk_wdata = w_plink;
                        end
                    end
                    n_state = S_UPD;
                end
            end

            // Read-modify-write of the existing path counts, pipelined.
            S_UPD: begin
                if (r_pend) begin
                    cnt_we    = 1'b1;
                    cnt_waddr = r_pend_addr;
                    cnt_wdata = sat_add(cnt_rdata, r_delta);
                end
                if (r_upd_k != r_depth) begin
                    cnt_re      = 1'b1;
                    cnt_raddr   = r_path[r_upd_k[IDX_W-1:0]];
                    n_pend_addr = r_path[r_upd_k[IDX_W-1:0]];
                    n_pend      = 1'b1;
                    n_upd_k     = r_upd_k + DEP_W'(1);
                end else begin
                    n_pend  = 1'b0;
                    n_state = (r_depth == DEP_W'(KEY_BITS)) ? S_DONE : S_ALLOC;
                end
            end

            // One new node a cycle, already linked to the node below it.
            S_ALLOC: begin
                lk_we     = 1'b1;
                lk_waddr  = w_newn;
                lk_wdata  = w_alink;
                cnt_we    = 1'b1;
                cnt_waddr = w_newn;
                cnt_wdata = sat_add('0, r_delta);
                n_free    = w_newn;
                n_depth   = r_depth + DEP_W'(1);
                if (w_last) begin
                    n_state = S_DONE;
                end
            end

            // Empty check on the two root children.
            S_QE0: begin
                cnt_re    = 1'b1;
                cnt_raddr = r_root0;
                n_state   = S_QE1;
            end

            S_QE1: begin
                n_nz0     = (r_root0 != '0) && (cnt_rdata != '0);
                cnt_re    = 1'b1;
                cnt_raddr = r_root1;
                n_state   = S_QE2;
            end

            S_QE2: begin
                if (!r_nz0 && !((r_root1 != '0) && (cnt_rdata != '0))) begin
                    n_empty = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_QA;
                end
            end

            // Query level, first half: fetch the opposite child's count.
            S_QA: begin
                n_opp     = w_oppv;
                n_same    = w_nxt;
                cnt_re    = 1'b1;
                cnt_raddr = w_oppv;
                n_state   = S_QB;
            end

            // Query level, second half: choose the branch, fetch its links.
            S_QB: begin
                if (w_qtake || (r_same != '0)) begin
                    if (w_qtake) begin
                        n_res[w_bidx] = 1'b1;
                    end
                    lk_re     = 1'b1;
                    lk_raddr  = w_qtarget;
                    n_node    = w_qtarget;
                    n_at_root = 1'b0;
                    if (w_last) begin
                        n_state = S_DONE;
                    end else begin
                        n_depth = r_depth + DEP_W'(1);
                        n_state = S_QA;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end

            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_max_xor = w_res64[KEY_W-1:0];
                    n_out_empty   = r_empty;
                    n_out_full    = r_full;
                    n_state       = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_free      <= '0;
            r_root0     <= '0;
            r_root1     <= '0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_free      <= n_free;
            r_root0     <= n_root0;
            r_root1     <= n_root1;
            r_pend      <= n_pend;
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        r_key         <= n_key;
        r_delta       <= n_delta;
        r_res         <= n_res;
        r_empty       <= n_empty;
        r_full        <= n_full;
        r_depth       <= n_depth;
        r_upd_k       <= n_upd_k;
        r_node        <= n_node;
        r_at_root     <= n_at_root;
        r_par_links   <= n_par_links;
        r_par_root    <= n_par_root;
        r_par_node    <= n_par_node;
        r_path        <= n_path;
        r_pend_addr   <= n_pend_addr;
        r_opp         <= n_opp;
        r_same        <= n_same;
        r_nz0         <= n_nz0;
        r_out_max_xor <= n_out_max_xor;
        r_out_empty   <= n_out_empty;
        r_out_full    <= n_out_full;
    end

    assign o_valid     = r_out_valid;
    assign o_max_xor   = r_out_max_xor;
    assign o_set_empty = r_out_empty;
    assign o_pool_full = r_out_full;

endmodule

@@ sv/btmx_checker.sv @@
// Port-level checks for binary_trie_max_xor, attached by the bind below.
// Depends on btmx_pkg for the field widths.
module btmx_checker
    import btmx_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_stall,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [KEY_W-1:0]          o_max_xor,
    input logic                      o_set_empty,
    input logic                      o_pool_full
);

    // A stalled result item holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_max_xor)
            && $stable(o_set_empty) && $stable(o_pool_full))
        else $error("result item changed while stalled");

    // An accepted item blocks the input on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after an item was taken");

    // A result is an update result or a query result, never both flags.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_set_empty && o_pool_full))
        else $error("empty and pool-full flags both set");

    // An empty query and a dropped update both report zero.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_set_empty |-> o_max_xor == '0)
        else $error("empty query with nonzero result");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pool_full |-> o_max_xor == '0)
        else $error("dropped update with nonzero result");

endmodule

bind binary_trie_max_xor btmx_checker u_btmx_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_max_xor   (o_max_xor),
    .o_set_empty (o_set_empty),
    .o_pool_full (o_pool_full)
);
